/* sv/pid4_pkg.sv */
// Shared types and constants for the four-wheel PID velocity controller.
// Payload structs, gain bundle, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package pid4_pkg;

    localparam int NUM_WHEELS = 4;
    localparam int VEL_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int TICK_W     = 32;
    localparam int DRIVE_W    = 32;
    localparam int ACC_W_DEF  = 48;
    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV = 2'd2;

    // gain reset values (Q8.8: 100.0, 0.0, 10.0)
    localparam logic [GAIN_W-1:0] PROP_RST  = 16'd25600;
    localparam logic [GAIN_W-1:0] INTEG_RST = 16'd0;
    localparam logic [GAIN_W-1:0] DERIV_RST = 16'd2560;

    typedef struct packed {
        logic [GAIN_W-1:0] prop;
        logic [GAIN_W-1:0] integ;
        logic [GAIN_W-1:0] deriv;
    } pid4_gains_t;

    typedef struct packed {
        logic        [TICK_W-1:0] now_ms;
        logic signed [VEL_W-1:0]  target_fl;
        logic signed [VEL_W-1:0]  target_fr;
        logic signed [VEL_W-1:0]  target_rl;
        logic signed [VEL_W-1:0]  target_rr;
        logic signed [VEL_W-1:0]  measured_fl;
        logic signed [VEL_W-1:0]  measured_fr;
        logic signed [VEL_W-1:0]  measured_rl;
        logic signed [VEL_W-1:0]  measured_rr;
    } pid4_in_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive_fl;
        logic signed [DRIVE_W-1:0] drive_fr;
        logic signed [DRIVE_W-1:0] drive_rl;
        logic signed [DRIVE_W-1:0] drive_rr;
        logic                      updated;
    } pid4_out_t;

endpackage

/* sv/pid4_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Divides an NW-bit numerator by a 32-bit tick count. Uses pid4_pkg.
`timescale 1ns / 1ps

module pid4_div
    import pid4_pkg::*;
#(
    parameter int NW = 35
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NW-1:0]     num,
    input  logic [TICK_W-1:0] den,
    output logic              done,
    output logic [NW-1:0]     quo
);

    localparam int CNT_W = $clog2(NW + 1);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NW-1:0]     num_reg;
    logic [TICK_W-1:0] rem_reg;
    logic [TICK_W-1:0] den_reg;
    logic              done_reg;

    logic [TICK_W:0]   trial;
    logic [TICK_W:0]   trial_sub;
    logic              qbit;

    // trial subtract of the next numerator bit
    always_comb
    begin
        trial     = {rem_reg, num_reg[NW-1]};
        trial_sub = trial - {1'b0, den_reg};
        qbit      = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: numerator shifts out, quotient shifts in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NW-2:0], qbit};
            rem_reg <= qbit ? trial_sub[TICK_W-1:0] : trial[TICK_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

/* sv/pid4_lane.sv */
// One wheel's PID core: error, saturating integral, shared-gain products,
// derivative divided by dt, saturation to 32 bits. Uses pid4_pkg, pid4_div.
`timescale 1ns / 1ps

module pid4_lane
    import pid4_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_W_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [VEL_W-1:0]   target,
    input  logic signed [VEL_W-1:0]   measured,
    input  logic [TICK_W-1:0]         dt,
    input  pid4_gains_t               gains,
    output logic                      done,
    output logic signed [DRIVE_W-1:0] drive
);

    localparam int ERR_W = VEL_W + 1;
    localparam int DIF_W = VEL_W + 2;
    localparam int EDT_W = ERR_W + TICK_W + 1;
    localparam int PP_W  = GAIN_W + 1 + ERR_W;
    localparam int DP_W  = GAIN_W + 1 + DIF_W;
    localparam int LO_W  = ACC_WIDTH / 2;
    localparam int HI_W  = ACC_WIDTH - LO_W;
    localparam int ILO_W = GAIN_W + LO_W;
    localparam int IHI_W = GAIN_W + 1 + HI_W;
    localparam int XW    = (ACC_WIDTH + GAIN_W + 2 > 66) ? ACC_WIDTH + GAIN_W + 2 : 66;

    localparam logic signed [XW-1:0] X_MAX64 = XW'(64'sh7FFF_FFFF_FFFF_FFFF);
    localparam logic signed [XW-1:0] X_MIN64 = XW'($signed(64'h8000_0000_0000_0000));
    localparam logic signed [XW-1:0] X_MAXAC = XW'($signed({1'b0, {(ACC_WIDTH-1){1'b1}}}));
    localparam logic signed [XW-1:0] X_MINAC = XW'($signed({1'b1, {(ACC_WIDTH-1){1'b0}}}));
    localparam logic signed [XW-1:0] X_MAX32 = XW'(32'sh7FFF_FFFF);
    localparam logic signed [XW-1:0] X_MIN32 = XW'($signed(32'h8000_0000));

    typedef enum logic [3:0] {
        L_IDLE, L_MUL, L_INT, L_IMLO, L_IMHI, L_SUM1, L_SUM2, L_WAIT, L_FIN1, L_FIN2
    } lane_state_t;

    function automatic logic signed [XW-1:0] sat64(input logic signed [XW-1:0] v);
        priority if (v > X_MAX64)
            return X_MAX64;
        else if (v < X_MIN64)
            return X_MIN64;
        else
            return v;
    endfunction

    function automatic logic signed [XW-1:0] sat_acc(input logic signed [XW-1:0] v);
        priority if (v > X_MAXAC)
            return X_MAXAC;
        else if (v < X_MINAC)
            return X_MINAC;
        else
            return v;
    endfunction

    lane_state_t                 state_reg;
    logic                        done_reg;
    logic                        qdone_reg;
    logic signed [ERR_W-1:0]     err_reg;
    logic signed [ERR_W-1:0]     prior_reg;
    logic signed [ACC_WIDTH-1:0] integ_reg;
    logic signed [DRIVE_W-1:0]   drive_reg;
    logic signed [XW-1:0]        edt_reg;
    logic signed [PP_W-1:0]      pp_reg;
    logic signed [DP_W-1:0]      dp_reg;
    logic [ILO_W-1:0]            ilo_reg;
    logic signed [IHI_W-1:0]     ihi_reg;
    logic signed [XW-1:0]        isat_reg;
    logic signed [XW-1:0]        s1_reg;
    logic signed [XW-1:0]        s2_reg;
    logic [DP_W-1:0]             quo_reg;

    logic signed [ERR_W-1:0]     err_in;
    logic signed [DIF_W-1:0]     dif;
    logic signed [EDT_W-1:0]     edt_full;
    logic signed [PP_W-1:0]      pp_full;
    logic signed [DP_W-1:0]      dp_full;
    logic signed [XW-1:0]        int_sum;
    logic signed [XW-1:0]        int_next;
    logic [ILO_W-1:0]            ilo_full;
    logic signed [IHI_W-1:0]     ihi_full;
    logic signed [XW-1:0]        iprod;
    logic signed [XW-1:0]        s1_next;
    logic signed [XW-1:0]        dterm;
    logic signed [XW-1:0]        s2_next;
    logic signed [XW-1:0]        shifted;
    logic signed [XW-1:0]        drv_sat;
    logic [DP_W-1:0]             dmag;
    logic                        div_start;
    logic                        div_done;
    logic [DP_W-1:0]             div_quo;

    // arithmetic for each step
    always_comb
    begin
        err_in   = ERR_W'(target) - ERR_W'(measured);
        dif      = DIF_W'(err_reg) - DIF_W'(prior_reg);
        edt_full = EDT_W'(err_reg) * EDT_W'($signed({1'b0, dt}));
        pp_full  = PP_W'($signed({1'b0, gains.prop})) * PP_W'(err_reg);
        dp_full  = DP_W'($signed({1'b0, gains.deriv})) * DP_W'(dif);
        int_sum  = XW'(integ_reg) + edt_reg;
        int_next = sat_acc(int_sum);
        ilo_full = ILO_W'(gains.integ) * ILO_W'(integ_reg[LO_W-1:0]);
        ihi_full = IHI_W'($signed({1'b0, gains.integ})) *
                   IHI_W'($signed(integ_reg[ACC_WIDTH-1:LO_W]));
        iprod    = (XW'(ihi_reg) <<< LO_W) + $signed(XW'(ilo_reg));
        s1_next  = sat64(XW'(pp_reg) + isat_reg);
        dterm    = dp_reg[DP_W-1] ? -$signed(XW'(quo_reg)) : $signed(XW'(quo_reg));
        s2_next  = sat64(s1_reg + dterm);
        shifted  = s2_reg >>> 8;
        priority if (shifted > X_MAX32)
            drv_sat = X_MAX32;
        else if (shifted < X_MIN32)
            drv_sat = X_MIN32;
        else
            drv_sat = shifted;
        dmag      = dp_reg[DP_W-1] ? DP_W'(-dp_reg) : DP_W'(dp_reg);
        div_start = (state_reg == L_INT);
    end

    // |derivative product| / dt
    pid4_div #(
        .NW (DP_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (dmag),
        .den   (dt),
        .done  (div_done),
        .quo   (div_quo)
    );

    // step sequencer and lane state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
            qdone_reg <= 1'b0;
            prior_reg <= '0;
            integ_reg <= '0;
            drive_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (div_done)
                qdone_reg <= 1'b1;
            unique case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        err_reg   <= err_in;
                        qdone_reg <= 1'b0;
                        state_reg <= L_MUL;
                    end
                end
                L_MUL:
                begin
                    edt_reg   <= sat64(XW'(edt_full));
                    pp_reg    <= pp_full;
                    dp_reg    <= dp_full;
                    state_reg <= L_INT;
                end
                L_INT:
                begin
                    integ_reg <= ACC_WIDTH'(int_next);
                    prior_reg <= err_reg;
                    state_reg <= L_IMLO;
                end
                L_IMLO:
                begin
                    ilo_reg   <= ilo_full;
                    state_reg <= L_IMHI;
                end
                L_IMHI:
                begin
                    ihi_reg   <= ihi_full;
                    state_reg <= L_SUM1;
                end
                L_SUM1:
                begin
                    isat_reg  <= sat64(iprod);
                    state_reg <= L_SUM2;
                end
                L_SUM2:
                begin
                    s1_reg    <= s1_next;
                    state_reg <= L_WAIT;
                end
                L_WAIT:
                begin
                    if (qdone_reg)
                    begin
                        quo_reg   <= div_quo;
                        state_reg <= L_FIN1;
                    end
                end
                L_FIN1:
                begin
                    s2_reg    <= s2_next;
                    state_reg <= L_FIN2;
                end
                L_FIN2:
                begin
                    drive_reg <= DRIVE_W'(drv_sat);
                    done_reg  <= 1'b1;
                    state_reg <= L_IDLE;
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    assign done  = done_reg;
    assign drive = drive_reg;

endmodule

/* sv/four_wheel_pid_velocity_control.sv */
// Four-wheel PID velocity controller, top level: handshake, gain registers,
// tick bookkeeping and merge of the four lane results. Uses pid4_pkg, pid4_lane.
`timescale 1ns / 1ps

// One input word carries a millisecond tick and a target and measured Q8.8
// velocity per wheel; exactly one output word follows each. When fewer than
// 2 ms have passed since the last update the stored drives repeat with
// updated = 0. Otherwise four lanes work side by side, each with its own
// divider for the derivative term, which yields one quotient bit per cycle
// over 35 bits. One word is in flight at a time; a finished result sits in
// the output register until taken. The user writes gains through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce this.

module four_wheel_pid_velocity_control
    import pid4_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_W_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pid4_in_t             in_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output pid4_out_t            out_word,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GAIN_W-1:0]    cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE, S_RUN, S_EMIT
    } top_state_t;

    top_state_t        state_reg;
    logic              start_reg;
    logic              upd_reg;
    logic              out_valid_reg;
    pid4_out_t         out_word_reg;
    logic [TICK_W-1:0] last_ms_reg;
    logic [TICK_W-1:0] dt_reg;
    pid4_in_t          item_reg;
    pid4_gains_t       gains_reg;

    logic                      accept;
    logic [TICK_W-1:0]         dt_in;
    logic                      hold;
    logic [NUM_WHEELS-1:0]     lane_done;
    logic signed [VEL_W-1:0]   tgt [NUM_WHEELS];
    logic signed [VEL_W-1:0]   meas [NUM_WHEELS];
    logic signed [DRIVE_W-1:0] drv [NUM_WHEELS];

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign dt_in    = in_word.now_ms - last_ms_reg;
    assign hold     = (dt_in[TICK_W-1:1] == '0);

    // unpack wheels
    assign tgt[0]  = item_reg.target_fl;
    assign tgt[1]  = item_reg.target_fr;
    assign tgt[2]  = item_reg.target_rl;
    assign tgt[3]  = item_reg.target_rr;
    assign meas[0] = item_reg.measured_fl;
    assign meas[1] = item_reg.measured_fr;
    assign meas[2] = item_reg.measured_rl;
    assign meas[3] = item_reg.measured_rr;

    // gain registers; writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.prop  <= PROP_RST;
            gains_reg.integ <= INTEG_RST;
            gains_reg.deriv <= DERIV_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PROP:  gains_reg.prop  <= cfg_data;
                REG_INTEG: gains_reg.integ <= cfg_data;
                REG_DERIV: gains_reg.deriv <= cfg_data;
                default:   ;
            endcase
        end
    end

    // per-wheel lanes
    for (genvar w = 0; w < NUM_WHEELS; w++)
    begin : g_lane
        pid4_lane #(
            .ACC_WIDTH (ACC_WIDTH)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (start_reg),
            .target   (tgt[w]),
            .measured (meas[w]),
            .dt       (dt_reg),
            .gains    (gains_reg),
            .done     (lane_done[w]),
            .drive    (drv[w])
        );
    end

    // capture input word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_word;
            dt_reg   <= dt_in;
        end
    end

    // control and merge of lane results into the output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            upd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            last_ms_reg   <= '0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        upd_reg <= !hold;
                        if (hold)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            start_reg   <= 1'b1;
                            last_ms_reg <= in_word.now_ms;
                            state_reg   <= S_RUN;
                        end
                    end
                end
                S_RUN:
                begin
                    if (&lane_done)
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg         <= 1'b1;
                        out_word_reg.drive_fl <= drv[0];
                        out_word_reg.drive_fr <= drv[1];
                        out_word_reg.drive_rl <= drv[2];
                        out_word_reg.drive_rr <= drv[3];
                        out_word_reg.updated  <= upd_reg;
                        state_reg             <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // lanes run in lockstep
    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_done == '0) || (&lane_done))
        else $error("lane done flags disagree");

    // lanes start only right after an accepted word
    a_start_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> $past(accept))
        else $error("lane start without accepted word");

    // tick of last update moves only with a recompute
    a_tick_with_start: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(last_ms_reg) |-> start_reg)
        else $error("last update tick changed without recompute");

    // a new result only comes out of the emit state
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("output word loaded outside emit");

endmodule

/* tb/four_wheel_pid_velocity_control_tb.sv */
// Testbench for the four-wheel PID velocity controller.
// Predicts every drive word in a scoreboard class and checks the block's output.
// Depends on pid4_pkg and four_wheel_pid_velocity_control.
`timescale 1ns / 1ps

module four_wheel_pid_velocity_control_tb;
    import pid4_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam longint ACC_HI = (64'sd1 <<< 47) - 1;
    localparam longint ACC_LO = -ACC_HI - 1;
    localparam longint S64_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam longint S64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    pid4_in_t   in_word = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    pid4_out_t  out_word;
    logic       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [GAIN_W-1:0]    cfg_data = '0;

    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_off = 1'b0;
    int quiet_cycles = 0;
    logic [TICK_W-1:0] tick = '0;

    four_wheel_pid_velocity_control dut (.*);

    always #5 clk = ~clk;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // Saturating helpers in 64-bit signed space
    function automatic longint mul_sat(input longint a, input longint b);
        longint p;
        if (a == 0 || b == 0)
            return 0;
        if ((a == -1 && b == S64_MIN) || (b == -1 && a == S64_MIN))
            return S64_MAX;
        p = a * b;
        if (p / b != a)
            return ((a < 0) != (b < 0)) ? S64_MIN : S64_MAX;
        return p;
    endfunction

    function automatic longint add_sat(input longint a, input longint b,
                                       input longint lo, input longint hi);
        if (b > 0 && a > hi - b)
            return hi;
        if (b < 0 && a < lo - b)
            return lo;
        return a + b;
    endfunction

    class pid_scoreboard;
        longint kp, ki, kd;
        longint integ[NUM_WHEELS];
        longint prev_err[NUM_WHEELS];
        longint drive[NUM_WHEELS];
        logic [TICK_W-1:0] last_ms;
        pid4_out_t pending[$];

        function new();
            kp = PROP_RST;
            ki = INTEG_RST;
            kd = DERIV_RST;
            last_ms = '0;
            foreach (integ[w])
            begin
                integ[w] = 0;
                prev_err[w] = 0;
                drive[w] = 0;
            end
        endfunction

        function void set_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] v);
            if (idx == REG_PROP)
                kp = v;
            else if (idx == REG_INTEG)
                ki = v;
            else if (idx == REG_DERIV)
                kd = v;
        endfunction

        // Compute the drive word that an accepted velocity word causes
        function void note_input(input pid4_in_t iw);
            logic [TICK_W-1:0] dt;
            longint tg[NUM_WHEELS], ms[NUM_WHEELS];
            longint e, s, d;
            pid4_out_t o;
            tg = '{longint'(iw.target_fl), longint'(iw.target_fr),
                   longint'(iw.target_rl), longint'(iw.target_rr)};
            ms = '{longint'(iw.measured_fl), longint'(iw.measured_fr),
                   longint'(iw.measured_rl), longint'(iw.measured_rr)};
            dt = iw.now_ms - last_ms;
            if (dt > 1)
            begin
                for (int w = 0; w < NUM_WHEELS; w++)
                begin
                    e = tg[w] - ms[w];
                    integ[w] = add_sat(integ[w], mul_sat(e, longint'(dt)), ACC_LO, ACC_HI);
                    s = mul_sat(kp, e);
                    s = add_sat(s, mul_sat(ki, integ[w]), S64_MIN, S64_MAX);
                    s = add_sat(s, mul_sat(kd, e - prev_err[w]) / longint'(dt),
                                S64_MIN, S64_MAX);
                    d = s >>> 8;
                    if (d > 64'sd2147483647)
                        d = 64'sd2147483647;
                    if (d < -64'sd2147483648)
                        d = -64'sd2147483648;
                    drive[w] = d;
                    prev_err[w] = e;
                end
                last_ms = iw.now_ms;
            end
            o.drive_fl = drive[0][31:0];
            o.drive_fr = drive[1][31:0];
            o.drive_rl = drive[2][31:0];
            o.drive_rr = drive[3][31:0];
            o.updated = (dt > 1);
            pending.push_back(o);
        endfunction

        task check_output(input pid4_out_t ow);
            pid4_out_t x;
            if (pending.size() == 0)
            begin
                report("unexpected word", 0, 0);
                return;
            end
            x = pending.pop_front();
            if (ow.drive_fl !== x.drive_fl) report("drive_fl", ow.drive_fl, x.drive_fl);
            if (ow.drive_fr !== x.drive_fr) report("drive_fr", ow.drive_fr, x.drive_fr);
            if (ow.drive_rl !== x.drive_rl) report("drive_rl", ow.drive_rl, x.drive_rl);
            if (ow.drive_rr !== x.drive_rr) report("drive_rr", ow.drive_rr, x.drive_rr);
            if (ow.updated !== x.updated) report("updated", ow.updated, x.updated);
        endtask
    endclass

    pid_scoreboard sb = new();

    // Receiver side: random stall, long hold-off on request
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            sb.check_output(out_word);
        if (in_valid && !in_stall)
            sb.note_input(in_word);
        out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Write enable stays up here; the caller drops it after the last write
    task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        sb.set_gain(idx, v);
    endtask

    task automatic set_gains(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                             input logic [GAIN_W-1:0] d);
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        write_gain(REG_PROP, p);
        write_gain(REG_INTEG, i);
        write_gain(REG_DERIV, d);
        // unused index must be ignored
        cfg_index <= REG_UNUSED;
        cfg_data <= GAIN_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offer one word and hold it until accepted; valid is left up on return
    task automatic send_word(input pid4_in_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic logic [VEL_W-1:0] rand_vel();
        case ($urandom_range(4))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return VEL_W'($urandom_range(511) - 256);
            default: return VEL_W'($urandom);
        endcase
    endfunction

    task automatic send_random(input int n);
        pid4_in_t w;
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(9))
                0: tick = tick + $urandom_range(1);        // held update
                1: tick = $urandom;                        // arbitrary jump
                2: tick = tick + 32'hffff_fff0 + $urandom_range(15);
                default: tick = tick + 2 + $urandom_range(30);
            endcase
            w.now_ms = tick;
            w.target_fl = rand_vel(); w.target_fr = rand_vel();
            w.target_rl = rand_vel(); w.target_rr = rand_vel();
            w.measured_fl = rand_vel(); w.measured_fr = rand_vel();
            w.measured_rl = rand_vel(); w.measured_rr = rand_vel();
            send_word(w);
        end
        in_valid <= 1'b0;
    endtask

    task automatic send_directed(input logic [TICK_W-1:0] t, input logic [VEL_W-1:0] tv,
                                 input logic [VEL_W-1:0] mv);
        pid4_in_t w;
        w.now_ms = t;
        w.target_fl = tv; w.target_fr = ~tv; w.target_rl = tv; w.target_rr = 16'h0;
        w.measured_fl = mv; w.measured_fr = ~mv; w.measured_rl = 16'h0; w.measured_rr = mv;
        tick = t;
        send_word(w);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: held words after reset, extremes, wrap, saturation
        send_directed(32'd0, 16'h7fff, 16'h8000);
        send_directed(32'd1, 16'h8000, 16'h7fff);
        send_directed(32'd2, 16'h7fff, 16'h8000);
        send_directed(32'd3, 16'h8000, 16'h7fff);
        send_directed(32'd5, 16'h0100, 16'h0080);
        send_directed(32'hffff_fffe, 16'h8000, 16'h7fff);
        send_directed(32'h0000_0003, 16'h7fff, 16'h8000);
        send_directed(32'h0000_0004, 16'h1234, 16'h0001);
        send_directed(32'h8000_0000, 16'hffff, 16'h0000);
        in_valid <= 1'b0;
        set_gains(16'hffff, 16'hffff, 16'hffff);
        for (int k = 0; k < 8; k++)
            send_directed(tick + 32'h7fff_0000, 16'h7fff, 16'h8000);
        send_directed(tick + 2, 16'h8000, 16'h7fff);
        send_directed(tick + 2, 16'h0000, 16'h0000);
        in_valid <= 1'b0;
        set_gains(16'h0000, 16'h0000, 16'h0000);
        send_directed(tick + 9, 16'h7fff, 16'h8000);
        send_directed(tick + 9, 16'h5555, 16'haaaa);
        in_valid <= 1'b0;

        // Random phases with different idling and gains
        set_gains(16'h0180, 16'h0003, 16'h0a00);
        send_idle_pct = 35; recv_idle_pct = 81;
        send_random(200);
        set_gains(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom));
        send_idle_pct = 81; recv_idle_pct = 35;
        send_random(200);
        set_gains(PROP_RST, 16'h0010, DERIV_RST);
        send_idle_pct = 0; recv_idle_pct = 0;
        // long receiver hold-off while words keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            send_random(250);
        join

        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* four_wheel_pid_velocity_control.f */
sv/pid4_pkg.sv
sv/pid4_div.sv
sv/pid4_lane.sv
sv/four_wheel_pid_velocity_control.sv
tb/four_wheel_pid_velocity_control_tb.sv
